@@ rtl/core/pdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants of the PLL divider setting calculator.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // Width of the frequency fields and of the serial divider.
  localparam int unsigned FreqW = 32;
  localparam int unsigned CntW  = $clog2(FreqW);

  // The reference is pre-divided in steps of this frequency.
  localparam logic [FreqW-1:0] PredivStepHz  = 32'd13500000;
  localparam int unsigned      PredivMaxCode = 3;
  localparam logic [FreqW-1:0] PredivLim1Hz  = PredivStepHz * 32'd1;
  localparam logic [FreqW-1:0] PredivLim2Hz  = PredivStepHz * 32'd2;
  localparam logic [FreqW-1:0] PredivLim3Hz  = PredivStepHz * 32'd3;
  localparam logic [FreqW-1:0] PredivLimMax  = PredivStepHz * 32'(PredivMaxCode + 1);

  localparam logic [FreqW-1:0] NmLimit  = 32'h0000_ffff;
  localparam logic [FreqW-1:0] RatioMin = 32'd2;
  localparam logic [FreqW-1:0] RatioMax = 32'd8;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_START   = 3'd2,
    OP_CAPTURE = 3'd3,
    OP_EMIT    = 3'd4
  } op_e;

  // Which division the shared divider is working on.
  typedef enum logic [2:0] {
    SEL_INT  = 3'd0,  // output / input
    SEL_PRE  = 3'd1,  // input / pre-divider
    SEL_FRAC = 3'd2,  // output / divided input
    SEL_GCD  = 3'd3,  // one Euclid step
    SEL_N    = 3'd4,  // remainder / gcd
    SEL_M    = 3'd5   // divided input / gcd
  } sel_e;

  typedef struct packed {
    op_e  op;
    sel_e sel;
    logic err;
  } cmd_t;

  typedef struct packed {
    logic fin_zero;
    logic fout_zero;
    logic div_busy;
    logic div_done;
    logic exact;
    logic prediv_ok;
    logic ratio_ok;
    logic b_zero;
    logic nm_ok;
  } sts_t;

endpackage

@@ rtl/core/pdc_if.sv @@
// ----------------------------------------------------------------------------
// pdc_if
// Valid/ready channels carrying request items and setting items.
// ----------------------------------------------------------------------------
interface pdc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] input_freq_hz;
  logic [31:0] output_freq_hz;

  modport source (output valid, output input_freq_hz, output output_freq_hz, input ready);
  modport sink   (input valid, input input_freq_hz, input output_freq_hz, output ready);
endinterface

interface pdc_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] pll_byte0;
  logic [7:0] pll_byte1;
  logic [7:0] pll_byte2;
  logic [7:0] pll_byte3;
  logic [7:0] pll_byte4;

  modport source (output valid, output status, output pll_byte0, output pll_byte1,
                  output pll_byte2, output pll_byte3, output pll_byte4, input ready);
  modport sink   (input valid, input status, input pll_byte0, input pll_byte1,
                  input pll_byte2, input pll_byte3, input pll_byte4, output ready);
endinterface

@@ rtl/core/pll_divider_config_calc.sv @@
// ----------------------------------------------------------------------------
// pll_divider_config_calc
// Computes fractional-N PLL setting bytes from input and output frequencies.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the block takes a new request once the
// previous one has been placed in the result register, so a finished result
// may still wait for its taker while the next request is accepted. All the
// arithmetic runs through a single restoring divider that yields one quotient
// bit per cycle. A disabled output or a zero reference finishes without any
// division. An exact integer ratio takes one division. A fractional ratio
// takes the integer division, the pre-division, the ratio division, one
// division per Euclid step of the greatest common divisor, and two divisions
// to reduce N and M. Any rejected request returns status 1 with all setting
// bytes zero.
module pll_divider_config_calc (
  input  logic          clk_i,
  input  logic          rst_ni,
  pdc_in_if.sink        in_chan,
  pdc_out_if.source     out_chan
);

  pdc_pkg::cmd_t cmd;
  pdc_pkg::sts_t sts;

  // Sequencer: owns both handshakes and the order of the divisions.
  pdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan.valid),
    .in_ready_o  (in_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: operand registers, the shared divider and the result register.
  pdc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .input_freq_hz_i  (in_chan.input_freq_hz),
    .output_freq_hz_i (in_chan.output_freq_hz),
    .sts_o            (sts),
    .status_o         (out_chan.status),
    .pll_byte0_o      (out_chan.pll_byte0),
    .pll_byte1_o      (out_chan.pll_byte1),
    .pll_byte2_o      (out_chan.pll_byte2),
    .pll_byte3_o      (out_chan.pll_byte3),
    .pll_byte4_o      (out_chan.pll_byte4)
  );

endmodule

@@ rtl/core/pdc_divider.sv @@
// ----------------------------------------------------------------------------
// pdc_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pdc_pkg::FreqW-1:0]   dividend_i,
  input  logic [pdc_pkg::FreqW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [pdc_pkg::FreqW-1:0]   quotient_o,
  output logic [pdc_pkg::FreqW-1:0]   remainder_o
);

  localparam int unsigned W = pdc_pkg::FreqW;

  logic                        busy_q, done_q;
  logic [pdc_pkg::CntW-1:0]    cnt_q;
  logic [W-1:0]                quo_q, rem_q, dvs_q;
  logic [W:0]                  trial;

  assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pdc_pkg::CntW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[W-2:0], quo_q[W-1]};
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // A result is only flagged at the end of a running division.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

@@ rtl/core/pdc_datapath.sv @@
// ----------------------------------------------------------------------------
// pdc_datapath
// Operand registers, shared divider and result register of the calculator.
// ----------------------------------------------------------------------------
module pdc_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pdc_pkg::cmd_t             cmd_i,
  input  logic [pdc_pkg::FreqW-1:0] input_freq_hz_i,
  input  logic [pdc_pkg::FreqW-1:0] output_freq_hz_i,
  output pdc_pkg::sts_t             sts_o,
  output logic                      status_o,
  output logic [7:0]                pll_byte0_o,
  output logic [7:0]                pll_byte1_o,
  output logic [7:0]                pll_byte2_o,
  output logic [7:0]                pll_byte3_o,
  output logic [7:0]                pll_byte4_o
);

  localparam int unsigned W = pdc_pkg::FreqW;

  logic [W-1:0]  fin_q, fout_q, fdiv_q, rem_q, a_q, b_q;
  logic [3:0]    r_q;
  logic [15:0]   n_q, m_q;
  logic [1:0]    pd_q, pd_code;
  logic          exact_q, ratio_ok_q, n_ok_q, m_ok_q;
  logic          status_q;
  logic [7:0]    byte_q [5];

  logic          div_start, div_busy, div_done;
  logic [W-1:0]  div_num, div_den, div_quo, div_rem;
  logic          quo_ratio_ok, quo_nm_ok;

  // Pre-divider code is ceil(fin / step) - 1, valid while fin is in range.
  always_comb begin
    priority if (fin_q <= pdc_pkg::PredivLim1Hz) pd_code = 2'd0;
    else if (fin_q <= pdc_pkg::PredivLim2Hz)     pd_code = 2'd1;
    else if (fin_q <= pdc_pkg::PredivLim3Hz)     pd_code = 2'd2;
    else                                         pd_code = 2'd3;
  end

  always_comb begin
    unique case (cmd_i.sel)
      pdc_pkg::SEL_INT:  begin div_num = fout_q; div_den = fin_q; end
      pdc_pkg::SEL_PRE:  begin div_num = fin_q;  div_den = {{(W-2){1'b0}}, pd_code} + 1'b1; end
      pdc_pkg::SEL_FRAC: begin div_num = fout_q; div_den = fdiv_q; end
      pdc_pkg::SEL_GCD:  begin div_num = a_q;    div_den = b_q; end
      pdc_pkg::SEL_N:    begin div_num = rem_q;  div_den = a_q; end
      pdc_pkg::SEL_M:    begin div_num = fdiv_q; div_den = a_q; end
      default:           begin div_num = fout_q; div_den = fin_q; end
    endcase
  end

  assign div_start = (cmd_i.op == pdc_pkg::OP_START);

  pdc_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_num),
    .divisor_i   (div_den),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign quo_ratio_ok = (div_quo >= pdc_pkg::RatioMin) && (div_quo <= pdc_pkg::RatioMax);
  assign quo_nm_ok    = (div_quo <= pdc_pkg::NmLimit);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      pdc_pkg::OP_LOAD: begin
        fin_q      <= input_freq_hz_i;
        fout_q     <= output_freq_hz_i;
        r_q        <= '0;
        n_q        <= '0;
        m_q        <= '0;
        pd_q       <= '0;
        n_ok_q     <= 1'b1;
        m_ok_q     <= 1'b1;
        ratio_ok_q <= 1'b1;
        exact_q    <= 1'b0;
      end
      pdc_pkg::OP_CAPTURE: begin
        unique case (cmd_i.sel)
          pdc_pkg::SEL_INT: begin
            r_q        <= div_quo[3:0];
            ratio_ok_q <= quo_ratio_ok;
            exact_q    <= (div_rem == '0);
          end
          pdc_pkg::SEL_PRE: begin
            fdiv_q <= div_quo;
            pd_q   <= pd_code;
          end
          pdc_pkg::SEL_FRAC: begin
            r_q        <= div_quo[3:0];
            ratio_ok_q <= quo_ratio_ok;
            rem_q      <= div_rem;
            a_q        <= fdiv_q;
            b_q        <= div_rem;
          end
          pdc_pkg::SEL_GCD: begin
            a_q <= b_q;
            b_q <= div_rem;
          end
          pdc_pkg::SEL_N: begin
            n_q    <= div_quo[15:0];
            n_ok_q <= quo_nm_ok;
          end
          pdc_pkg::SEL_M: begin
            m_q    <= div_quo[15:0];
            m_ok_q <= quo_nm_ok;
          end
          default: ;
        endcase
      end
      pdc_pkg::OP_EMIT: begin
        status_q <= cmd_i.err;
        if (cmd_i.err) begin
          for (int i = 0; i < 5; i++) byte_q[i] <= '0;
        end else begin
          byte_q[0] <= m_q[15:8];
          byte_q[1] <= m_q[7:0];
          byte_q[2] <= n_q[15:8];
          byte_q[3] <= n_q[7:0];
          byte_q[4] <= {1'b0, r_q, pd_q, (m_q != '0)};
        end
      end
      default: ;
    endcase
  end

  assign sts_o.fin_zero  = (fin_q == '0);
  assign sts_o.fout_zero = (fout_q == '0);
  assign sts_o.div_busy  = div_busy;
  assign sts_o.div_done  = div_done;
  assign sts_o.exact     = exact_q;
  assign sts_o.prediv_ok = (fin_q <= pdc_pkg::PredivLimMax);
  assign sts_o.ratio_ok  = ratio_ok_q;
  assign sts_o.b_zero    = (b_q == '0);
  assign sts_o.nm_ok     = n_ok_q & m_ok_q;

  assign status_o    = status_q;
  assign pll_byte0_o = byte_q[0];
  assign pll_byte1_o = byte_q[1];
  assign pll_byte2_o = byte_q[2];
  assign pll_byte3_o = byte_q[3];
  assign pll_byte4_o = byte_q[4];

endmodule

@@ rtl/core/pdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdc_ctrl
// Sequencer that steps the datapath through the divisions of one item.
// ----------------------------------------------------------------------------
module pdc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pdc_pkg::sts_t sts_i,
  output pdc_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_CLASSIFY = 6'b000010,
    S_START    = 6'b000100,
    S_WAIT     = 6'b001000,
    S_DECIDE   = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  pdc_pkg::sel_e sel_q, sel_d;
  logic          err_q, err_d;
  logic          out_valid_q, out_valid_d;
  pdc_pkg::cmd_t cmd;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    err_d   = err_q;
    cmd.op  = pdc_pkg::OP_NONE;
    cmd.sel = sel_q;
    cmd.err = err_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.op  = pdc_pkg::OP_LOAD;
          state_d = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        priority if (sts_i.fout_zero) begin
          err_d   = 1'b0;
          state_d = S_FINISH;
        end else if (sts_i.fin_zero) begin
          err_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          sel_d   = pdc_pkg::SEL_INT;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd.op  = pdc_pkg::OP_START;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.div_done) begin
          cmd.op  = pdc_pkg::OP_CAPTURE;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_START;
        unique case (sel_q)
          pdc_pkg::SEL_INT: begin
            priority if (sts_i.exact) begin
              err_d   = !sts_i.ratio_ok;
              state_d = S_FINISH;
            end else if (!sts_i.prediv_ok) begin
              err_d   = 1'b1;
              state_d = S_FINISH;
            end else begin
              sel_d = pdc_pkg::SEL_PRE;
            end
          end
          pdc_pkg::SEL_PRE: sel_d = pdc_pkg::SEL_FRAC;
          pdc_pkg::SEL_FRAC: begin
            priority if (!sts_i.ratio_ok) begin
              err_d   = 1'b1;
              state_d = S_FINISH;
            end else if (sts_i.b_zero) begin
              sel_d = pdc_pkg::SEL_N;
            end else begin
              sel_d = pdc_pkg::SEL_GCD;
            end
          end
          pdc_pkg::SEL_GCD: begin
            if (sts_i.b_zero) sel_d = pdc_pkg::SEL_N;
          end
          pdc_pkg::SEL_N: sel_d = pdc_pkg::SEL_M;
          pdc_pkg::SEL_M: begin
            err_d   = !sts_i.nm_ok;
            state_d = S_FINISH;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.op  = pdc_pkg::OP_EMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (cmd.op == pdc_pkg::OP_EMIT) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= pdc_pkg::SEL_INT;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // The result register is never overwritten while it holds an untaken item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == pdc_pkg::OP_EMIT) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  // A division is only started on an idle divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == pdc_pkg::OP_START) |-> !sts_i.div_busy)
    else $error("divider restarted while busy");

  // Divider results only arrive while the sequencer waits for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_WAIT))
    else $error("divider finished outside the wait state");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the PLL divider setting calculator. Frequency request
// items are driven through the request channel, each accepted item is
// predicted by a behavioral copy of the divider math, and every setting item
// that comes back is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog limit is well above the time that a single fractional request
  // with a long Euclid chain takes plus the longest receiver hold-off.
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldOffCycles = 600;
  localparam int unsigned IdlePercent   = 21;
  localparam int unsigned MaxPrinted    = 40;

  // Reference clocks that real systems use. They give well-formed fractions.
  localparam logic [31:0] CommonRefHz [10] = '{
    32'd12000000, 32'd12288000, 32'd11289600, 32'd24576000, 32'd22579200,
    32'd27000000, 32'd19200000, 32'd26000000, 32'd48000000, 32'd54000000
  };

  // One setting item as it leaves the block.
  typedef struct packed {
    logic       status;
    logic [7:0] pll_byte0;
    logic [7:0] pll_byte1;
    logic [7:0] pll_byte2;
    logic [7:0] pll_byte3;
    logic [7:0] pll_byte4;
  } pll_setting_t;

  // A predicted setting, kept with the request that caused it.
  typedef struct {
    logic [31:0]  fin;
    logic [31:0]  fout;
    pll_setting_t setting;
  } pending_setting_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pdc_in_if  req_chan ();
  pdc_out_if setting_chan ();

  pll_divider_config_calc u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (req_chan),
    .out_chan (setting_chan)
  );

  pending_setting_t pending_settings [$];
  int unsigned      error_count   = 0;
  bit               idling_on     = 1'b1;
  int unsigned      hold_off_req  = 0;

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction: the divider math done directly on integers.
  // --------------------------------------------------------------------------
  function automatic pll_setting_t calc_pll_setting(input logic [31:0] fin,
                                                    input logic [31:0] fout);
    pll_setting_t s;
    logic [63:0]  prediv;
    logic [31:0]  fdiv;
    logic [31:0]  ratio;
    logic [31:0]  rem;
    logic [31:0]  num_n;
    logic [31:0]  den_m;
    logic [31:0]  pdcode;
    logic [31:0]  ga;
    logic [31:0]  gb;
    logic [31:0]  gt;
    s = '0;
    // A disabled output gives an all-zero, valid setting.
    if (fout == 32'd0) begin
      return s;
    end
    // A zero reference cannot be divided and is flagged.
    if (fin == 32'd0) begin
      s.status = 1'b1;
      return s;
    end
    if (fout % fin != 32'd0) begin
      // The ceiling is taken in 64 bits so that it cannot wrap near the top.
      prediv = (64'(fin) + 64'(pdc_pkg::PredivStepHz) - 64'd1) /
               64'(pdc_pkg::PredivStepHz);
      fdiv   = fin / prediv[31:0];
      ratio  = fout / fdiv;
      rem    = fout % fdiv;
      ga = rem;
      gb = fdiv;
      while (gb != 32'd0) begin
        gt = ga % gb;
        ga = gb;
        gb = gt;
      end
      // With no remainder the gcd is fdiv itself, so N is 0 and M is 1.
      num_n  = rem / ga;
      den_m  = fdiv / ga;
      pdcode = prediv[31:0] - 32'd1;
    end else begin
      ratio  = fout / fin;
      num_n  = 32'd0;
      den_m  = 32'd0;
      pdcode = 32'd0;
    end
    if (num_n > pdc_pkg::NmLimit || den_m > pdc_pkg::NmLimit ||
        pdcode > pdc_pkg::PredivMaxCode ||
        ratio > pdc_pkg::RatioMax || ratio < pdc_pkg::RatioMin) begin
      s.status = 1'b1;
      return s;
    end
    s.pll_byte0 = den_m[15:8];
    s.pll_byte1 = den_m[7:0];
    s.pll_byte2 = num_n[15:8];
    s.pll_byte3 = num_n[7:0];
    s.pll_byte4 = {1'b0, ratio[3:0], pdcode[1:0], den_m != 32'd0};
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Inputs change on the falling edge; acceptance is seen on
  // the rising edge, where the prediction is queued.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [31:0] fin, input logic [31:0] fout);
    pending_setting_t p;
    while (idling_on && $urandom_range(0, 99) < IdlePercent) begin
      @(negedge clk_i);
      req_chan.valid = 1'b0;
    end
    @(negedge clk_i);
    req_chan.valid          = 1'b1;
    req_chan.input_freq_hz  = fin;
    req_chan.output_freq_hz = fout;
    do begin
      @(posedge clk_i);
    end while (!req_chan.ready);
    p.fin     = fin;
    p.fout    = fout;
    p.setting = calc_pll_setting(fin, fout);
    pending_settings.push_back(p);
  endtask

  // Lowers valid and waits until every predicted setting has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    req_chan.valid = 1'b0;
    while (pending_settings.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random request mix: mostly well-formed fractional requests, half around real
  // reference clocks, plus exact ratios, tiny values and raw 32-bit noise.
  task automatic gen_request(output logic [31:0] fin, output logic [31:0] fout);
    int unsigned kind;
    int unsigned ratio;
    int unsigned den;
    logic [63:0] prediv;
    logic [31:0] fdiv;
    logic [31:0] frac;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      fin  = $urandom;
      fout = $urandom;
      // Zero fields now and then, on either side.
      if ($urandom_range(0, 15) == 0) fin = '0;
      if ($urandom_range(0, 15) == 0) fout = '0;
    end else if (kind < 30) begin
      fin   = $urandom_range(1, 60000000);
      ratio = $urandom_range(0, 10);
      fout  = fin * ratio;
    end else if (kind < 45) begin
      fin  = $urandom_range(1, 1000);
      fout = $urandom_range(1, 10000);
    end else begin
      if ($urandom_range(0, 1) == 0) begin
        fin = CommonRefHz[$urandom_range(0, 9)];
      end else begin
        fin = $urandom_range(1, 60000000);
      end
      prediv = (64'(fin) + 64'(pdc_pkg::PredivStepHz) - 64'd1) /
               64'(pdc_pkg::PredivStepHz);
      fdiv   = fin / prediv[31:0];
      ratio  = $urandom_range(1, 9);
      if ($urandom_range(0, 1) == 0) begin
        // A fraction with a small denominator usually fits in 16 bits.
        den  = $urandom_range(1, 200);
        frac = (fdiv / den) * $urandom_range(0, den - 1);
      end else begin
        frac = $urandom_range(0, fdiv - 1);
      end
      fout = fdiv * ratio + frac;
    end
  endtask

  // --------------------------------------------------------------------------
  // Setting side. Ready follows the idling pattern unless a hold-off was
  // asked for, which this process counts down on its own.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    setting_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left          = hold_left - 1;
        setting_chan.ready = 1'b0;
      end else if (idling_on) begin
        setting_chan.ready = ($urandom_range(0, 99) >= IdlePercent);
      end else begin
        setting_chan.ready = 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  // Every accepted setting item is checked against the oldest prediction.
  always @(posedge clk_i) begin
    pending_setting_t p;
    pll_setting_t     got;
    string            req;
    if (rst_ni && setting_chan.valid && setting_chan.ready) begin
      got = {setting_chan.status, setting_chan.pll_byte0, setting_chan.pll_byte1,
             setting_chan.pll_byte2, setting_chan.pll_byte3, setting_chan.pll_byte4};
      if (pending_settings.size() == 0) begin
        report_mismatch($sformatf("setting item 0x%011h with none expected", got));
      end else begin
        p   = pending_settings.pop_front();
        req = $sformatf("in=%0d out=%0d", p.fin, p.fout);
        if (got.status !== p.setting.status)
          report_mismatch($sformatf("%s status %b, expected %b", req, got.status,
                                    p.setting.status));
        if (got.pll_byte0 !== p.setting.pll_byte0)
          report_mismatch($sformatf("%s pll_byte0 0x%h, expected 0x%h", req,
                                    got.pll_byte0, p.setting.pll_byte0));
        if (got.pll_byte1 !== p.setting.pll_byte1)
          report_mismatch($sformatf("%s pll_byte1 0x%h, expected 0x%h", req,
                                    got.pll_byte1, p.setting.pll_byte1));
        if (got.pll_byte2 !== p.setting.pll_byte2)
          report_mismatch($sformatf("%s pll_byte2 0x%h, expected 0x%h", req,
                                    got.pll_byte2, p.setting.pll_byte2));
        if (got.pll_byte3 !== p.setting.pll_byte3)
          report_mismatch($sformatf("%s pll_byte3 0x%h, expected 0x%h", req,
                                    got.pll_byte3, p.setting.pll_byte3));
        if (got.pll_byte4 !== p.setting.pll_byte4)
          report_mismatch($sformatf("%s pll_byte4 0x%h, expected 0x%h", req,
                                    got.pll_byte4, p.setting.pll_byte4));
      end
    end
  end

  // The watchdog ends the run when no item moves on either channel for too
  // long; a lost or stuck result lands here.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_chan.valid && req_chan.ready) ||
          (setting_chan.valid && setting_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("pll_divider_config_calc verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Disabled output and zero reference in every combination.
  task automatic test_disabled_and_zero_ref();
    send_request(32'd0, 32'd0);
    send_request(32'hffff_ffff, 32'd0);
    send_request(32'd0, 32'd1);
    send_request(32'd0, 32'hffff_ffff);
  endtask

  // Exact multiples: ratios 2 to 8 pass; 1 and 9 are rejected, as are a huge ratio and ratio 1 at full scale.
  task automatic test_integer_ratios();
    for (int unsigned r = 1; r <= 9; r++) begin
      send_request(32'd12288000, 32'd12288000 * r);
    end
    send_request(32'd1, 32'hffff_ffff);
    send_request(32'hffff_ffff, 32'hffff_ffff);
  endtask

  // Fractional requests at the edges of every rejection rule.
  task automatic test_fractional_corners();
    // An ordinary audio setting.
    send_request(32'd12000000, 32'd49152000);
    // The remainder after pre-division is zero, so N is 0 and M is 1.
    send_request(32'd27000000, 32'd40500000);
    // The largest allowed pre-divider, then one hertz past it.
    send_request(32'd54000000, 32'd100000000);
    send_request(32'd54000001, 32'd100000000);
    // Ratio at the top and bottom of the range, and just outside.
    send_request(32'd2, 32'd17);
    send_request(32'd2, 32'd19);
    send_request(32'd2, 32'd5);
    send_request(32'd3, 32'd4);
    // M far beyond 16 bits.
    send_request(32'd12000001, 32'd48000005);
    // Pre-divider rounding at the very top of the input range.
    send_request(32'hffff_ffff, 32'hffff_fffe);
  endtask

  task automatic test_random_requests(input int unsigned count);
    logic [31:0] fin;
    logic [31:0] fout;
    for (int unsigned i = 0; i < count; i++) begin
      gen_request(fin, fout);
      send_request(fin, fout);
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back(input int unsigned count);
    idling_on = 1'b0;
    test_random_requests(count);
    idling_on = 1'b1;
  endtask

  // The receiver stalls for a long time while requests keep coming, so the
  // result register fills and the block has to hold off its input.
  task automatic test_output_backpressure();
    hold_off_req = HoldOffCycles;
    for (int unsigned i = 0; i < 8; i++) begin
      send_request(CommonRefHz[i], CommonRefHz[i] * (i % 7 + 2));
    end
    wait_drained();
  endtask

  // The sender stops until every result is back, then starts again.
  task automatic test_pause_until_drained();
    test_random_requests(40);
    wait_drained();
    test_random_requests(40);
  endtask

  initial begin
    req_chan.valid          = 1'b0;
    req_chan.input_freq_hz  = '0;
    req_chan.output_freq_hz = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_disabled_and_zero_ref();
    test_integer_ratios();
    test_fractional_corners();
    test_random_requests(1500);
    test_back_to_back(200);
    test_output_backpressure();
    test_pause_until_drained();

    // Let any stray result show up before the verdict.
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("pll_divider_config_calc verification clean");
    end else begin
      $display("pll_divider_config_calc verification failed");
    end
    $finish;
  end

endmodule
